[hw/rtl/two_histogram_min_error_cut_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the minimum-error histogram cut block
// Shared forms for the concurrent checks, all clocked on the rising edge.
// ----------------------------------------------------------------------------
`ifndef TWO_HISTOGRAM_MIN_ERROR_CUT_ASSERT_SVH
`define TWO_HISTOGRAM_MIN_ERROR_CUT_ASSERT_SVH

// Same-cycle implication, switched off while reset is asserted.
`define THMEC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("thmec assertion failed");

// Next-cycle implication, switched off while reset is asserted.
`define THMEC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("thmec assertion failed");

// Next-cycle implication that is also checked across reset.
`define THMEC_ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("thmec assertion failed");

`endif

[hw/rtl/thmec_pkg.sv]
// ----------------------------------------------------------------------------
// thmec_pkg
// Widths, defaults and the bin item type of the minimum-error cut block.
// ----------------------------------------------------------------------------
package thmec_pkg;

  // Fixed field widths of the channels.
  localparam int COUNT_W = 32;
  localparam int CUT_W   = 13;
  localparam int COST_W  = 44;

  // Count bits that take part in the sums.
  localparam int COUNT_BITS = 32;

  // Default number of bins in one histogram.
  localparam int MAX_BINS_DEF = 4096;

  // One bin of the histogram pair as it travels inside the block.
  typedef struct packed {
    logic [COUNT_W-1:0] count_a;
    logic [COUNT_W-1:0] count_b;
    logic               last_bin;
  } bin_t;

endpackage

[hw/rtl/thmec_in_if.sv]
// ----------------------------------------------------------------------------
// thmec_in_if
// Bin channel: one transaction carries both counts of one bin.
// ----------------------------------------------------------------------------
interface thmec_in_if;
  logic                          valid;
  logic                          ready;
  logic [thmec_pkg::COUNT_W-1:0] count_a;
  logic [thmec_pkg::COUNT_W-1:0] count_b;
  logic                          last_bin;

  modport source (output valid, count_a, count_b, last_bin, input ready);
  modport sink   (input valid, count_a, count_b, last_bin, output ready);
endinterface

[hw/rtl/thmec_out_if.sv]
// ----------------------------------------------------------------------------
// thmec_out_if
// Result channel: one transaction carries the cut of one histogram pair.
// ----------------------------------------------------------------------------
interface thmec_out_if;
  logic                         valid;
  logic                         ready;
  logic [thmec_pkg::CUT_W-1:0]  cut_bin;
  logic [thmec_pkg::COST_W-1:0] min_cost;
  logic                         bin_overflow;

  modport source (output valid, cut_bin, min_cost, bin_overflow, input ready);
  modport sink   (input valid, cut_bin, min_cost, bin_overflow, output ready);
endinterface

[hw/rtl/thmec_acc.sv]
// ----------------------------------------------------------------------------
// thmec_acc
// Input register and running accumulator: keeps the sum of (B - A), the
// total of A and the earliest bin with the smallest running difference.
// ----------------------------------------------------------------------------
module thmec_acc #(
  parameter int MAX_BINS = thmec_pkg::MAX_BINS_DEF
) (
  input  logic                                               clk,
  input  logic                                               rst_n,
  input  logic                                               bin_valid,
  output logic                                               bin_ready,
  input  thmec_pkg::bin_t                                    bin_i,
  output logic                                               fin_valid,
  input  logic                                               fin_ready,
  output logic [thmec_pkg::COUNT_BITS+$clog2(MAX_BINS+1):0]  fin_best_diff,
  output logic [thmec_pkg::COST_W-1:0]                       fin_total_a,
  output logic [$clog2(MAX_BINS+1)-1:0]                      fin_best_bin,
  output logic                                               fin_overflow
);

  localparam int BIN_W  = $clog2(MAX_BINS + 1);
  localparam int DIFF_W = thmec_pkg::COUNT_BITS + BIN_W + 1;
  localparam int TOT_W  = thmec_pkg::COST_W;

  // Input register.
  logic            s1_valid_r, s1_valid_nxt;
  thmec_pkg::bin_t s1_item_r, s1_item_nxt;

  // Running state of the current histogram pair.
  logic [DIFF_W-1:0] diff_r, diff_nxt;
  logic [TOT_W-1:0]  total_r, total_nxt;
  logic [DIFF_W-1:0] best_diff_r, best_diff_nxt;
  logic [BIN_W-1:0]  best_bin_r, best_bin_nxt;
  logic [BIN_W-1:0]  idx_r, idx_nxt;
  logic              ovf_r, ovf_nxt;

  // Finished result waiting for the output stage.
  logic              fin_valid_r, fin_valid_nxt;
  logic [DIFF_W-1:0] fin_diff_r, fin_diff_nxt;
  logic [TOT_W-1:0]  fin_total_r, fin_total_nxt;
  logic [BIN_W-1:0]  fin_bin_r, fin_bin_nxt;
  logic              fin_ovf_r, fin_ovf_nxt;

  logic              acc_go;
  logic              in_range;
  logic              better;
  logic [DIFF_W-1:0] a_ext, b_ext, diff_step;
  logic [TOT_W-1:0]  a_tot;
  logic [DIFF_W-1:0] upd_diff, upd_best_diff;
  logic [TOT_W-1:0]  upd_total;
  logic [BIN_W-1:0]  upd_idx, upd_best_bin;
  logic              upd_ovf;

  // A last bin may only be folded in once the result slot is free.
  assign acc_go    = s1_valid_r &
                     (!s1_item_r.last_bin || !fin_valid_r || fin_ready);
  assign bin_ready = !s1_valid_r || acc_go;

  // Input register loads whenever it empties or moves on.
  always_comb begin
    s1_valid_nxt = s1_valid_r;
    s1_item_nxt  = s1_item_r;
    if (bin_ready) begin
      s1_valid_nxt = bin_valid;
      s1_item_nxt  = bin_i;
    end
  end

  // One bin step: an add of B minus A and a signed compare to the best.
  always_comb begin
    a_ext     = DIFF_W'(s1_item_r.count_a[thmec_pkg::COUNT_BITS-1:0]);
    b_ext     = DIFF_W'(s1_item_r.count_b[thmec_pkg::COUNT_BITS-1:0]);
    a_tot     = TOT_W'(s1_item_r.count_a[thmec_pkg::COUNT_BITS-1:0]);
    diff_step = diff_r + b_ext - a_ext;
    in_range  = idx_r < BIN_W'(MAX_BINS);
    better    = (idx_r == '0) || ($signed(diff_step) < $signed(best_diff_r));

    upd_diff      = diff_r;
    upd_total     = total_r;
    upd_idx       = idx_r;
    upd_best_diff = best_diff_r;
    upd_best_bin  = best_bin_r;
    upd_ovf       = ovf_r;
    if (in_range) begin
      upd_diff  = diff_step;
      upd_total = total_r + a_tot;
      upd_idx   = idx_r + BIN_W'(1);
      if (better) begin
        upd_best_diff = diff_step;
        upd_best_bin  = idx_r + BIN_W'(1);
      end
    end else begin
      upd_ovf = 1'b1;
    end
  end

  // State update; a last bin hands its result over and clears the state.
  always_comb begin
    diff_nxt      = diff_r;
    total_nxt     = total_r;
    idx_nxt       = idx_r;
    best_diff_nxt = best_diff_r;
    best_bin_nxt  = best_bin_r;
    ovf_nxt       = ovf_r;
    fin_valid_nxt = fin_valid_r && !fin_ready;
    fin_diff_nxt  = fin_diff_r;
    fin_total_nxt = fin_total_r;
    fin_bin_nxt   = fin_bin_r;
    fin_ovf_nxt   = fin_ovf_r;
    if (acc_go) begin
      if (s1_item_r.last_bin) begin
        fin_valid_nxt = 1'b1;
        fin_diff_nxt  = upd_best_diff;
        fin_total_nxt = upd_total;
        fin_bin_nxt   = upd_best_bin;
        fin_ovf_nxt   = upd_ovf;
        diff_nxt      = '0;
        total_nxt     = '0;
        idx_nxt       = '0;
        best_diff_nxt = '0;
        best_bin_nxt  = BIN_W'(1);
        ovf_nxt       = 1'b0;
      end else begin
        diff_nxt      = upd_diff;
        total_nxt     = upd_total;
        idx_nxt       = upd_idx;
        best_diff_nxt = upd_best_diff;
        best_bin_nxt  = upd_best_bin;
        ovf_nxt       = upd_ovf;
      end
    end
  end

  // Control and running state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      fin_valid_r <= 1'b0;
      diff_r      <= '0;
      total_r     <= '0;
      idx_r       <= '0;
      best_diff_r <= '0;
      best_bin_r  <= BIN_W'(1);
      ovf_r       <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      fin_valid_r <= fin_valid_nxt;
      diff_r      <= diff_nxt;
      total_r     <= total_nxt;
      idx_r       <= idx_nxt;
      best_diff_r <= best_diff_nxt;
      best_bin_r  <= best_bin_nxt;
      ovf_r       <= ovf_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    s1_item_r   <= s1_item_nxt;
    fin_diff_r  <= fin_diff_nxt;
    fin_total_r <= fin_total_nxt;
    fin_bin_r   <= fin_bin_nxt;
    fin_ovf_r   <= fin_ovf_nxt;
  end

  assign fin_valid     = fin_valid_r;
  assign fin_best_diff = fin_diff_r;
  assign fin_total_a   = fin_total_r;
  assign fin_best_bin  = fin_bin_r;
  assign fin_overflow  = fin_ovf_r;

endmodule

[hw/rtl/two_histogram_min_error_cut.sv]
// ----------------------------------------------------------------------------
// two_histogram_min_error_cut
// Minimum-error cut between a class-A and a class-B histogram.
// ----------------------------------------------------------------------------
// Bins stream in from bin 1 upward, one transaction per bin, and the block
// takes one bin every clock cycle unless a last bin is waiting in the input
// register. The rate is set by the running accumulator, which does one add
// of (B - A) and one signed compare against the best difference per cycle.
// For each cut bin b the cost is the B counts in bins 1..b plus the A counts
// above b; the earliest bin with the least cost wins. The transaction marked
// last_bin is held in the input register, folded into the accumulator's
// result slot and then moved to the output register, from which its result
// is offered. The next histogram pair may follow in the very next cycle. A
// last bin waits in the input register only while an earlier result is still
// held in both the accumulator and the output register. Bins beyond MAX_BINS
// are not summed and set bin_overflow in the result.
module two_histogram_min_error_cut #(
  parameter int MAX_BINS = thmec_pkg::MAX_BINS_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  thmec_in_if.sink      in_ch,
  thmec_out_if.source   out_ch
);

  localparam int BIN_W   = $clog2(MAX_BINS + 1);
  localparam int DIFF_W  = thmec_pkg::COUNT_BITS + BIN_W + 1;
  localparam int COST_W  = thmec_pkg::COST_W;
  localparam int CUT_W   = thmec_pkg::CUT_W;
  localparam int SUM_W   = (DIFF_W > COST_W) ? DIFF_W : COST_W;
  localparam int CUTX_W  = (BIN_W > CUT_W) ? BIN_W : CUT_W;

  thmec_pkg::bin_t   bin_item;
  logic              fin_valid;
  logic              fin_ready;
  logic [DIFF_W-1:0] fin_best_diff;
  logic [COST_W-1:0] fin_total_a;
  logic [BIN_W-1:0]  fin_best_bin;
  logic              fin_overflow;

  logic              out_valid_r, out_valid_nxt;
  logic [CUT_W-1:0]  cut_r, cut_nxt;
  logic [COST_W-1:0] cost_r, cost_nxt;
  logic              ovf_r, ovf_nxt;
  logic [SUM_W-1:0]  cost_sum;
  logic [CUTX_W-1:0] cut_ext;

  assign bin_item.count_a  = in_ch.count_a;
  assign bin_item.count_b  = in_ch.count_b;
  assign bin_item.last_bin = in_ch.last_bin;

  // Accumulator over the bins of one histogram pair.
  thmec_acc #(
    .MAX_BINS (MAX_BINS)
  ) u_acc (
    .clk           (clk),
    .rst_n         (rst_n),
    .bin_valid     (in_ch.valid),
    .bin_ready     (in_ch.ready),
    .bin_i         (bin_item),
    .fin_valid     (fin_valid),
    .fin_ready     (fin_ready),
    .fin_best_diff (fin_best_diff),
    .fin_total_a   (fin_total_a),
    .fin_best_bin  (fin_best_bin),
    .fin_overflow  (fin_overflow)
  );

  // Cost is the best running difference plus the total of A.
  assign fin_ready = !out_valid_r || out_ch.ready;
  assign cost_sum  = SUM_W'($signed(fin_best_diff)) + SUM_W'(fin_total_a);
  assign cut_ext   = CUTX_W'(fin_best_bin);

  // Output register: loads when empty or when its transaction completes.
  always_comb begin
    out_valid_nxt = out_valid_r && !out_ch.ready;
    cut_nxt       = cut_r;
    cost_nxt      = cost_r;
    ovf_nxt       = ovf_r;
    if (fin_ready) begin
      out_valid_nxt = fin_valid;
      cut_nxt       = cut_ext[CUT_W-1:0];
      cost_nxt      = cost_sum[COST_W-1:0];
      ovf_nxt       = fin_overflow;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cut_r  <= cut_nxt;
    cost_r <= cost_nxt;
    ovf_r  <= ovf_nxt;
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.cut_bin      = cut_r;
  assign out_ch.min_cost     = cost_r;
  assign out_ch.bin_overflow = ovf_r;

endmodule

[hw/rtl/thmec_chk.sv]
// ----------------------------------------------------------------------------
// thmec_chk
// Port-level checks of the minimum-error cut block, bound to the top level.
// ----------------------------------------------------------------------------
`include "two_histogram_min_error_cut_assert.svh"

module thmec_chk (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_ready,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [thmec_pkg::CUT_W-1:0]  cut_bin,
  input logic [thmec_pkg::COST_W-1:0] min_cost,
  input logic                         bin_overflow
);

  logic out_stall;

  // A result is offered but not taken in this cycle.
  assign out_stall = out_valid && !out_ready;

  // Reset empties the result register.
  `THMEC_ASSERT_NEXT_ALWAYS(a_reset_no_result, clk, !rst_n, !out_valid)

  // Reset empties the input register, so a bin can be taken at once.
  `THMEC_ASSERT_NEXT_ALWAYS(a_reset_ready, clk, !rst_n, in_ready)

  // A result that is not taken stays offered.
  `THMEC_ASSERT_NEXT(a_out_hold, clk, rst_n, out_stall, out_valid)

  // A stalled result keeps its fields.
  `THMEC_ASSERT_NEXT(a_out_stable, clk, rst_n, out_stall, $stable({cut_bin, min_cost, bin_overflow}))

endmodule

bind two_histogram_min_error_cut thmec_chk u_thmec_chk (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_ready     (in_ch.ready),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .cut_bin      (out_ch.cut_bin),
  .min_cost     (out_ch.min_cost),
  .bin_overflow (out_ch.bin_overflow)
);
